### sv/htlp_pkg.sv
// ----------------------------------------------------------------------------
// Hash table package
// Shared sizes, constants, codes and types of the linear probing hash table.
// ----------------------------------------------------------------------------
package htlp_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
   localparam int KEY_BYTES   = 8;
   localparam int KEY_BITS    = 8 * KEY_BYTES;
   localparam int LEN_BITS    = 4;
   localparam int VALUE_BITS  = 32;

   localparam logic [31:0] FNV_BASIS = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME = 32'd16777619;

   typedef enum logic [2:0] {
      STATUS_INSERTED = 3'd0,
      STATUS_UPDATED  = 3'd1,
      STATUS_FULL     = 3'd2,
      STATUS_FOUND    = 3'd3,
      STATUS_MISS     = 3'd4
   } status_type;

   typedef struct packed {
      logic [KEY_BITS-1:0]   key;
      logic [LEN_BITS-1:0]   len;
      logic [VALUE_BITS-1:0] value;
   } entry_type;

   function automatic logic [KEY_BITS-1:0] key_mask(input logic [LEN_BITS-1:0] len);
      logic [KEY_BITS-1:0] mask;
      mask = '0;
      for (int i = 0; i < KEY_BYTES; i++) begin
         if (LEN_BITS'(i) < len) begin
            mask[8*i +: 8] = 8'hFF;
         end
      end
      return mask;
   endfunction

endpackage

### sv/htlp_hash.sv
// ----------------------------------------------------------------------------
// FNV-1a hash unit
// Folds one key byte per cycle into a 32-bit FNV-1a hash.
// ----------------------------------------------------------------------------
module htlp_hash import htlp_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [KEY_BITS-1:0] key,
   input  logic [LEN_BITS-1:0] len,
   output logic                done,
   output logic [31:0]         hash
);

   logic                run_ff, run_in;
   logic [31:0]         hash_ff, hash_in;
   logic [LEN_BITS-1:0] cnt_ff, cnt_in;
   logic [LEN_BITS-1:0] len_ff, len_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [31:0]         mixed;

   assign mixed = hash_ff ^ {24'd0, key_ff[7:0]};
   assign done  = run_ff && (cnt_ff == len_ff);
   assign hash  = hash_ff;

   always_comb begin
      run_in  = run_ff;
      hash_in = hash_ff;
      cnt_in  = cnt_ff;
      len_in  = len_ff;
      key_in  = key_ff;
      if (start) begin
         run_in  = 1'b1;
         hash_in = FNV_BASIS;
         cnt_in  = '0;
         len_in  = len;
         key_in  = key;
      end else if (run_ff) begin
         if (cnt_ff == len_ff) begin
            run_in = 1'b0;
         end else begin
            hash_in = 32'(mixed * FNV_PRIME);
            cnt_in  = cnt_ff + LEN_BITS'(1);
            key_in  = key_ff >> 8;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
      hash_ff <= hash_in;
      cnt_ff  <= cnt_in;
      len_ff  <= len_in;
      key_ff  <= key_in;
   end

endmodule

### sv/htlp_table.sv
// ----------------------------------------------------------------------------
// Slot table
// Slot memory with one write and one registered read port, plus valid bits.
// ----------------------------------------------------------------------------
module htlp_table import htlp_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic [IDX_BITS-1:0] rd_addr,
   output logic                rd_valid,
   output entry_type           rd_entry,
   input  logic                wr_en,
   input  logic [IDX_BITS-1:0] wr_addr,
   input  entry_type           wr_entry
);

   entry_type              slot_mem_ff [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] valid_ff;
   logic                   rd_valid_ff;
   entry_type              rd_entry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
      rd_valid_ff <= valid_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem_ff[wr_addr] <= wr_entry;
      end
      rd_entry_ff <= slot_mem_ff[rd_addr];
   end

   assign rd_valid = rd_valid_ff;
   assign rd_entry = rd_entry_ff;

endmodule

### sv/hash_table_linear_probe_unit.sv
// Steps: accept the item, hash the key (one FNV-1a round per key byte), then
// for each probed slot a registered slot read and a compare, and last load the
// result register. One item at a time: a new item is taken only once the last
// result has been handed to the response register.
// Reset clears all slot valid bits at once; keys and values need no clearing.
// ----------------------------------------------------------------------------
// Hash table with linear probing
// Insert and find on an open addressing table keyed by FNV-1a hashes.
// ----------------------------------------------------------------------------
module hash_table_linear_probe_unit import htlp_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_type,
   input  logic [KEY_BITS-1:0] req_key_bytes,
   input  logic [3:0]          req_key_length,
   input  logic [31:0]         req_value_in,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_status,
   output logic [31:0]         rsp_value_out,
   output logic [7:0]          rsp_slot_index
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_HASH   = 5'b00010,
      ST_READ   = 5'b00100,
      ST_CMP    = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   logic                  find_ff, find_in;
   entry_type             req_ff, req_in;
   logic [IDX_BITS-1:0]   idx_ff, idx_in;
   logic [IDX_BITS-1:0]   probe_ff, probe_in;
   status_type            res_status_ff, res_status_in;
   logic [31:0]           res_value_ff, res_value_in;
   logic [7:0]            res_slot_ff, res_slot_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [31:0]           rsp_value_ff, rsp_value_in;
   logic [7:0]            rsp_slot_ff, rsp_slot_in;

   logic                  accept;
   logic [LEN_BITS-1:0]   len_sat;
   logic                  hash_done;
   logic [31:0]           hash;
   logic                  rd_valid;
   entry_type             rd_entry;
   logic                  wr_en;
   logic                  hit;
   logic [IDX_BITS-1:0]   idx_next;

   assign accept  = req_valid && !req_stall;
   assign len_sat = (req_key_length > LEN_BITS'(KEY_BYTES)) ? LEN_BITS'(KEY_BYTES)
                                                            : req_key_length;

   htlp_hash u_hash (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .key   (req_in.key),
      .len   (req_in.len),
      .done  (hash_done),
      .hash  (hash)
   );

   htlp_table u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_addr  (idx_ff),
      .rd_valid (rd_valid),
      .rd_entry (rd_entry),
      .wr_en    (wr_en),
      .wr_addr  (idx_ff),
      .wr_entry (req_ff)
   );

   assign hit      = rd_valid && (rd_entry.len == req_ff.len) && (rd_entry.key == req_ff.key);
   assign idx_next = (idx_ff == IDX_BITS'(TABLE_DEPTH - 1)) ? '0 : idx_ff + IDX_BITS'(1);
   assign wr_en    = (state_ff == ST_CMP) && !find_ff && (hit || !rd_valid);

   always_comb begin
      state_in      = state_ff;
      find_in       = find_ff;
      req_in        = req_ff;
      idx_in        = idx_ff;
      probe_in      = probe_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      res_slot_in   = res_slot_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_slot_in   = rsp_slot_ff;
      if (accept) begin
         find_in      = req_type;
         req_in.len   = len_sat;
         req_in.key   = req_key_bytes & key_mask(len_sat);
         req_in.value = VALUE_BITS'(req_value_in);
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            if (hash_done) begin
               idx_in   = hash[IDX_BITS-1:0];
               probe_in = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            res_value_in = '0;
            res_slot_in  = 8'(idx_ff);
            state_in     = ST_FINISH;
            priority if (hit) begin
               if (find_ff) begin
                  res_status_in = STATUS_FOUND;
                  res_value_in  = 32'(rd_entry.value);
               end else begin
                  res_status_in = STATUS_UPDATED;
               end
            end else if (!rd_valid) begin
               res_status_in = find_ff ? STATUS_MISS : STATUS_INSERTED;
               if (find_ff) begin
                  res_slot_in = '0;
               end
            end else if (probe_ff == IDX_BITS'(TABLE_DEPTH - 1)) begin
               res_status_in = find_ff ? STATUS_MISS : STATUS_FULL;
               res_slot_in   = '0;
            end else begin
               idx_in   = idx_next;
               probe_in = probe_ff + IDX_BITS'(1);
               state_in = ST_READ;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_value_in  = res_value_ff;
               rsp_slot_in   = res_slot_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      find_ff       <= find_in;
      req_ff        <= req_in;
      idx_ff        <= idx_in;
      probe_ff      <= probe_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_value_out  = rsp_value_ff;
   assign rsp_slot_index = rsp_slot_ff;

   a_accept_starts_hash: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_HASH))
      else $error("accepted item did not start hashing");

   a_write_only_on_resolve: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_CMP) && !find_ff)
      else $error("slot write outside an insert resolution");

   a_value_only_on_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != STATUS_FOUND) |-> (rsp_value_ff == '0))
      else $error("nonzero value on a result other than found");

   a_slot_zero_on_failure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && ((rsp_status_ff == STATUS_FULL) || (rsp_status_ff == STATUS_MISS))
      |-> (rsp_slot_ff == '0))
      else $error("nonzero slot index on a miss or full result");

endmodule

### tb/hash_table_linear_probe_unit_test.sv
// ----------------------------------------------------------------------------
// Hash table linear probe unit testbench
// Sends insert and find items to the table and checks every result item
// against a mirror of the slot store. The mirror hashes each key with FNV-1a
// and probes linearly, with wrap-around, to work out the result. A short
// directed part covers empty, saturated and zero-length keys, collisions and
// wrap-around. Random traffic follows, drawn mostly from a pool of repeated
// keys. The run ends by filling the table and probing it while full.
// ----------------------------------------------------------------------------
package htlp_test_pkg;
   import htlp_pkg::*;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_FIND   = 1'b1;

   typedef struct {
      status_type       status;
      logic [31:0]      value;
      logic [7:0]       slot;
   } lookup_result_type;

   class table_mirror_type;
      bit                    slot_used  [TABLE_DEPTH];
      logic [KEY_BITS-1:0]   slot_key   [TABLE_DEPTH];
      logic [LEN_BITS-1:0]   slot_len   [TABLE_DEPTH];
      logic [VALUE_BITS-1:0] slot_value [TABLE_DEPTH];
      lookup_result_type     awaited [$];
      int                    mismatches;

      function logic [KEY_BITS-1:0] byte_mask(logic [LEN_BITS-1:0] len);
         logic [KEY_BITS-1:0] mask;
         mask = '0;
         for (int i = 0; i < KEY_BYTES; i++) begin
            if (i < len) begin
               mask[8*i +: 8] = 8'hFF;
            end
         end
         return mask;
      endfunction

      function logic [31:0] fnv1a_hash(logic [KEY_BITS-1:0] key, logic [LEN_BITS-1:0] len);
         logic [31:0] h;
         h = FNV_BASIS;
         for (int i = 0; i < KEY_BYTES; i++) begin
            if (i < len) begin
               h = (h ^ 32'(key[8*i +: 8])) * FNV_PRIME;
            end
         end
         return h;
      endfunction

      function logic [IDX_BITS-1:0] home_slot(logic [KEY_BITS-1:0] key,
                                              logic [LEN_BITS-1:0] len);
         logic [31:0] h;
         h = fnv1a_hash(key & byte_mask(len), len);
         return IDX_BITS'(h % TABLE_DEPTH);
      endfunction

      function void note_request(logic kind, logic [KEY_BITS-1:0] key_in,
                                 logic [LEN_BITS-1:0] len_in, logic [31:0] value_in);
         logic [LEN_BITS-1:0] len;
         logic [KEY_BITS-1:0] key;
         logic [IDX_BITS-1:0] idx;
         bit                  hit;
         bit                  vacant;
         lookup_result_type   r;
         len = (len_in > KEY_BYTES) ? LEN_BITS'(KEY_BYTES) : len_in;
         key = key_in & byte_mask(len);
         idx = home_slot(key, len);
         hit = 1'b0;
         vacant = 1'b0;
         for (int n = 0; n < TABLE_DEPTH && !hit && !vacant; n++) begin
            if (!slot_used[idx]) begin
               vacant = 1'b1;
            end else if (slot_len[idx] == len && slot_key[idx] == key) begin
               hit = 1'b1;
            end else begin
               idx = (int'(idx) == TABLE_DEPTH - 1) ? '0 : idx + 1'b1;
            end
         end
         r.status = STATUS_MISS;
         r.value = '0;
         r.slot = '0;
         if (kind == REQ_FIND) begin
            if (hit) begin
               r.status = STATUS_FOUND;
               r.value = 32'(slot_value[idx]);
               r.slot = 8'(idx);
            end
         end else if (hit) begin
            slot_value[idx] = VALUE_BITS'(value_in);
            r.status = STATUS_UPDATED;
            r.slot = 8'(idx);
         end else if (vacant) begin
            slot_used[idx] = 1'b1;
            slot_key[idx] = key;
            slot_len[idx] = len;
            slot_value[idx] = VALUE_BITS'(value_in);
            r.status = STATUS_INSERTED;
            r.slot = 8'(idx);
         end else begin
            r.status = STATUS_FULL;
         end
         awaited.push_back(r);
      endfunction

      task report_mismatch(string what);
         $display("MISMATCH: %s", what);
         mismatches++;
      endtask

      task check_result(logic [2:0] status, logic [31:0] value, logic [7:0] slot);
         lookup_result_type want;
         if (awaited.size() == 0) begin
            report_mismatch($sformatf("result item with none awaited: status %0d slot %0d",
                                      status, slot));
         end else begin
            want = awaited.pop_front();
            if (status !== 3'(want.status)) begin
               report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
            end
            if (value !== want.value) begin
               report_mismatch($sformatf("value %h, expected %h", value, want.value));
            end
            if (slot !== want.slot) begin
               report_mismatch($sformatf("slot %0d, expected %0d", slot, want.slot));
            end
         end
      endtask
   endclass
endpackage

module hash_table_linear_probe_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import htlp_pkg::*;
   import htlp_test_pkg::*;

   localparam int         POOL_SIZE    = 120;
   localparam int         RANDOM_ITEMS = 1250;
   localparam int         QUIET_LIMIT  = 4000;
   localparam int         HOLD_AT      = 200;
   localparam int         HOLD_CYCLES  = 300;
   localparam int         DRAIN_CYCLES = 40;
   localparam logic [7:0] FILL_TAG     = 8'hA5;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_type = REQ_INSERT;
   logic [KEY_BITS-1:0] req_key_bytes = '0;
   logic [3:0]          req_key_length = '0;
   logic [31:0]         req_value_in = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [2:0]          rsp_status;
   logic [31:0]         rsp_value_out;
   logic [7:0]          rsp_slot_index;
   bit                  steady = 1'b0;
   table_mirror_type    mirror = new();

   hash_table_linear_probe_unit uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_key_bytes  (req_key_bytes),
      .req_key_length (req_key_length),
      .req_value_in   (req_value_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_value_out  (rsp_value_out),
      .rsp_slot_index (rsp_slot_index)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            mirror.note_request(req_type, req_key_bytes, req_key_length, req_value_in);
         end
         if (rsp_valid && !rsp_stall) begin
            mirror.check_result(rsp_status, rsp_value_out, rsp_slot_index);
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      wait (!reset);
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("end of test: mismatches");
      $finish;
   end

   // The receiver holds off once for a long stretch so that the block backs up.
   initial begin
      int taken;
      bit held;
      taken = 0;
      held = 1'b0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            taken++;
         end
         if (!held && taken == HOLD_AT) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_stall <= !steady && ($urandom_range(0, 99) < 33);
         end
      end
   end

   task automatic send_request(logic kind, logic [KEY_BITS-1:0] key, logic [3:0] len,
                               logic [31:0] value);
      while (!steady && $urandom_range(0, 99) < 33) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_key_bytes <= key;
      req_key_length <= len;
      req_value_in <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   function automatic logic [KEY_BITS-1:0] random_key();
      logic [KEY_BITS-1:0] k;
      k = {$urandom, $urandom};
      if (k[63:56] == FILL_TAG) begin
         k[63:56] = ~FILL_TAG;
      end
      return k;
   endfunction

   function automatic logic [KEY_BITS-1:0] fill_key(int n);
      return {FILL_TAG, 24'h0, 32'(n)};
   endfunction

   initial begin
      logic [KEY_BITS-1:0] chain [4];
      logic [KEY_BITS-1:0] pool_key [POOL_SIZE];
      logic [3:0]          pool_len [POOL_SIZE];
      logic [KEY_BITS-1:0] key;
      logic [3:0]          len;
      logic                kind;
      int                  found;
      int                  p;

      // Short keys that all start probing at the last slot, so the chain wraps.
      found = 0;
      for (int k = 1; k < 65536 && found < 4; k++) begin
         if (int'(mirror.home_slot(64'(k), 4'd2)) == TABLE_DEPTH - 1) begin
            chain[found] = 64'(k);
            found++;
         end
      end
      for (int i = 0; i < POOL_SIZE; i++) begin
         pool_key[i] = random_key();
         pool_len[i] = 4'($urandom_range(1, 8));
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_request(REQ_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'hFFFF_FFFF);
      send_request(REQ_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 32'hFFFF_FFFF);
      send_request(REQ_FIND, 64'h0, 4'd0, 32'h0);
      send_request(REQ_INSERT, 64'h5555_5555_5555_5555, 4'd0, 32'h0);
      send_request(REQ_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'h0);
      send_request(REQ_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 32'h1234_5678);
      send_request(REQ_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 4'd9, 32'h0);
      send_request(REQ_INSERT, 64'h0, 4'd8, 32'hA5A5_A5A5);
      send_request(REQ_FIND, 64'h0, 4'd8, 32'h0);
      send_request(REQ_INSERT, 64'hFFFF_FFFF_FFFF_FF00, 4'd1, 32'h0000_0001);
      send_request(REQ_FIND, 64'h0000_0000_1234_5600, 4'd1, 32'h0);
      send_request(REQ_FIND, 64'h0, 4'd2, 32'h0);
      send_request(REQ_INSERT, 64'hFFFF_FFFF_DEAD_BEEF, 4'd4, 32'h8000_0000);
      send_request(REQ_FIND, 64'hFFFF_FFFF_DEAD_BEEF, 4'd3, 32'h0);
      for (int i = 0; i < 3; i++) begin
         send_request(REQ_INSERT, chain[i], 4'd2, $urandom);
      end
      send_request(REQ_FIND, chain[2], 4'd2, 32'h0);
      send_request(REQ_FIND, chain[3], 4'd2, 32'h0);
      send_request(REQ_INSERT, chain[1], 4'd2, 32'h7FFF_FFFF);
      send_request(REQ_FIND, chain[1] | 64'hFFFF_FFFF_FFFF_0000, 4'd2, 32'h0);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         steady = (i >= 600 && i < 900);
         kind = 1'($urandom_range(0, 1));
         if ($urandom_range(0, 9) == 0) begin
            key = random_key();
            len = 4'($urandom_range(0, 15));
         end else begin
            p = $urandom_range(0, POOL_SIZE - 1);
            len = pool_len[p];
            if (len == 4'd8 && $urandom_range(0, 1) == 1) begin
               len = 4'($urandom_range(9, 15));
            end
            key = (pool_key[p] & mirror.byte_mask(len)) |
                  (random_key() & ~mirror.byte_mask(len));
         end
         send_request(kind, key, len, $urandom);
      end
      steady = 1'b0;

      // Fill every slot, then probe the full table.
      for (int n = 0; n < TABLE_DEPTH + 20; n++) begin
         send_request(REQ_INSERT, fill_key(n), 4'd8, $urandom);
      end
      for (int n = 0; n < 10; n++) begin
         send_request(REQ_FIND, fill_key(TABLE_DEPTH + 100 + n), 4'd8, $urandom);
         send_request(REQ_FIND, fill_key($urandom_range(0, TABLE_DEPTH - 1)), 4'd8, $urandom);
      end
      for (int n = 0; n < 5; n++) begin
         p = $urandom_range(0, POOL_SIZE - 1);
         send_request(REQ_INSERT, pool_key[p], pool_len[p], $urandom);
         send_request(REQ_INSERT, fill_key($urandom_range(0, TABLE_DEPTH - 1)), 4'd8,
                      $urandom);
      end
      req_valid <= 1'b0;

      while (mirror.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mirror.mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule
